>>> sv/assert_macros.svh
// Assertion macros for the task queue RTL.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked at every clock edge outside reset.
`define PTQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define PTQ_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PTQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/ptq_pkg.sv
// Shared types and constants for the priority task queue.
// No dependencies.
`timescale 1ns / 1ps

package ptq_pkg;

   localparam int OP_W   = 2;
   localparam int PRIO_W = 8;
   localparam int SLOT_W = 5;
   localparam int DATA_W = 32;

   localparam logic [OP_W-1:0] OP_ADD      = 2'd0;
   localparam logic [OP_W-1:0] OP_DISPATCH = 2'd1;
   localparam logic [OP_W-1:0] OP_FINISH   = 2'd2;

   // One queue position as held by a cell.
   typedef struct packed {
      logic              valid;
      logic              running;
      logic [SLOT_W-1:0] slot;
      logic [PRIO_W-1:0] prio;
      logic [DATA_W-1:0] handle;
      logic [DATA_W-1:0] arg;
   } entry_type;

   // Command broadcast to every cell of the row.
   typedef struct packed {
      logic              insert_en;
      logic              remove_en;
      logic              running;
      logic [SLOT_W-1:0] slot;
      logic [PRIO_W-1:0] prio;
      logic [DATA_W-1:0] handle;
      logic [DATA_W-1:0] arg;
   } cell_ctl_type;

endpackage

>>> sv/priority_task_queue_unit.sv
// Priority task queue: up to SLOTS tasks held in a row of cells sorted by descending
// priority, first in first out within one priority. A beat first registers the command,
// then lets the whole cell row insert, remove or mark the head running in one shift
// while the result is loaded into the output register. A new beat is accepted as soon
// as the previous one has reached that register, so a waiting result does not block
// acceptance of the next command, but holds that command's shift until it is taken.
// Depends on ptq_pkg, ptq_cell and ptq_slot_alloc.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module priority_task_queue_unit
   import ptq_pkg::*;
#(
   parameter int SLOTS = 32
)
(
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_stall,
   input  logic [OP_W-1:0]   req_opcode,
   input  logic [PRIO_W-1:0] req_priority_req,
   input  logic [DATA_W-1:0] req_task_handle,
   input  logic [DATA_W-1:0] req_task_arg,
   input  logic [SLOT_W-1:0] req_slot_index,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_ok,
   output logic [SLOT_W-1:0] rsp_slot,
   output logic              rsp_preempt,
   output logic [DATA_W-1:0] rsp_out_handle,
   output logic [DATA_W-1:0] rsp_out_arg
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   logic [OP_W-1:0]   cmd_opcode_ff;
   logic [PRIO_W-1:0] cmd_prio_ff;
   logic [DATA_W-1:0] cmd_handle_ff;
   logic [DATA_W-1:0] cmd_arg_ff;
   logic [SLOT_W-1:0] cmd_slot_ff;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              rsp_ok_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic              rsp_preempt_ff;
   logic [DATA_W-1:0] rsp_handle_ff;
   logic [DATA_W-1:0] rsp_arg_ff;

   logic              req_take;
   logic              fire;
   logic              any_free;
   logic [SLOT_W-1:0] low_slot;
   logic              query_free;
   logic [SLOTS-1:0]  free_mask;

   entry_type         cell_q [SLOTS];
   logic [SLOTS-1:0]  keep_vec;
   logic [SLOTS-1:0]  gone_vec;
   logic [SLOTS-1:0]  valid_vec;
   entry_type         head;
   cell_ctl_type      ctl;

   logic              add_ok;
   logic              disp_ok;
   logic              fin_ok;
   logic              pre;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign fire      = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_opcode_ff <= req_opcode;
         cmd_prio_ff   <= req_priority_req;
         cmd_handle_ff <= req_task_handle;
         cmd_arg_ff    <= req_task_arg;
         cmd_slot_ff   <= req_slot_index;
      end
   end

   // The queue is full exactly when no slot is free, since queued and used slots agree.
   assign head    = cell_q[0];
   assign pre     = !head.valid || (cmd_prio_ff > head.prio);
   assign add_ok  = (cmd_opcode_ff == OP_ADD) && any_free;
   assign disp_ok = (cmd_opcode_ff == OP_DISPATCH) && head.valid && !head.running;
   assign fin_ok  = (cmd_opcode_ff == OP_FINISH) && !query_free;

   always_comb begin
      ctl.insert_en = fire && add_ok;
      ctl.remove_en = fire && fin_ok;
      ctl.running   = pre;
      ctl.slot      = (cmd_opcode_ff == OP_ADD) ? low_slot : cmd_slot_ff;
      ctl.prio      = cmd_prio_ff;
      ctl.handle    = cmd_handle_ff;
      ctl.arg       = cmd_arg_ff;
   end

   ptq_slot_alloc #(
      .SLOTS (SLOTS)
   ) u_alloc (
      .clock      (clock),
      .reset      (reset),
      .alloc_en   (ctl.insert_en),
      .release_en (ctl.remove_en),
      .query_slot (cmd_slot_ff),
      .any_free   (any_free),
      .low_slot   (low_slot),
      .query_free (query_free),
      .free_mask  (free_mask)
   );

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      entry_type left_e;
      entry_type right_e;
      logic      left_k;
      logic      left_g;
      logic      run_set;

      if (i == 0) begin : g_first
         assign left_e  = '0;
         assign left_k  = 1'b1;
         assign left_g  = 1'b0;
         assign run_set = fire && disp_ok;
      end else begin : g_rest
         assign left_e  = cell_q[i-1];
         assign left_k  = keep_vec[i-1];
         assign left_g  = gone_vec[i-1];
         assign run_set = 1'b0;
      end

      if (i == SLOTS - 1) begin : g_last
         assign right_e = '0;
      end else begin : g_inner
         assign right_e = cell_q[i+1];
      end

      ptq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .set_run     (run_set),
         .left_entry  (left_e),
         .left_keep   (left_k),
         .left_gone   (left_g),
         .right_entry (right_e),
         .entry       (cell_q[i]),
         .keep        (keep_vec[i]),
         .gone        (gone_vec[i])
      );

      assign valid_vec[i] = cell_q[i].valid;
   end

   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ok_ff      <= add_ok || disp_ok || fin_ok;
         rsp_preempt_ff <= add_ok && pre;
         if (add_ok) begin
            rsp_slot_ff <= low_slot;
         end else if (disp_ok) begin
            rsp_slot_ff <= head.slot;
         end else if (fin_ok) begin
            rsp_slot_ff <= cmd_slot_ff;
         end else begin
            rsp_slot_ff <= '0;
         end
         if (add_ok && pre) begin
            rsp_handle_ff <= cmd_handle_ff;
            rsp_arg_ff    <= cmd_arg_ff;
         end else if (disp_ok) begin
            rsp_handle_ff <= head.handle;
            rsp_arg_ff    <= head.arg;
         end else begin
            rsp_handle_ff <= '0;
            rsp_arg_ff    <= '0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_preempt    = rsp_preempt_ff;
   assign rsp_out_handle = rsp_handle_ff;
   assign rsp_out_arg    = rsp_arg_ff;

   // Occupied cells always form an unbroken run from the head.
   `PTQ_ASSERT(a_cells_packed, clock, reset, (valid_vec & (valid_vec + SLOTS'(1))) == '0, "queue cells not packed from the head")
   // Every slot is either free or held by exactly one queued cell.
   `PTQ_ASSERT(a_slots_balance, clock, reset, ($countones(valid_vec) + $countones(free_mask)) == SLOTS, "free map and queue disagree")
   // A command that completes its work always lands in the output register.
   `PTQ_ASSERT_NEXT(a_fire_to_rsp, clock, reset, fire, rsp_valid_ff && (state_ff == ST_IDLE), "completed beat lost")
   // No new beat is taken while one is still in the cell row.
   `PTQ_ASSERT_IMPL(a_single_beat, clock, reset, state_ff == ST_EXEC, !req_take, "beat accepted while busy")

endmodule

>>> sv/ptq_cell.sv
// One position of the ordered queue: holds an entry and shifts with its neighbors.
// Depends on ptq_pkg.
`timescale 1ns / 1ps

module ptq_cell
   import ptq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  logic         set_run,
   input  entry_type    left_entry,
   input  logic         left_keep,
   input  logic         left_gone,
   input  entry_type    right_entry,
   output entry_type    entry,
   output logic         keep,
   output logic         gone
);

   entry_type entry_ff;
   entry_type entry_in;
   entry_type new_entry;
   logic      match;

   assign entry = entry_ff;

   // Entries are sorted, so keep is true for a prefix of the row.
   assign keep  = entry_ff.valid && (entry_ff.prio >= ctl.prio);
   assign match = entry_ff.valid && (entry_ff.slot == ctl.slot);
   assign gone  = left_gone || match;

   always_comb begin
      new_entry.valid   = 1'b1;
      new_entry.running = ctl.running;
      new_entry.slot    = ctl.slot;
      new_entry.prio    = ctl.prio;
      new_entry.handle  = ctl.handle;
      new_entry.arg     = ctl.arg;
   end

   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert_en) begin
         if (!keep) begin
            entry_in = left_keep ? new_entry : left_entry;
         end
      end else if (ctl.remove_en) begin
         // Every cell at or behind the removed one pulls from its right.
         if (gone) begin
            entry_in = right_entry;
         end
      end else if (set_run) begin
         entry_in.running = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule

>>> sv/ptq_slot_alloc.sv
// Free-slot bitmap with lowest-free-slot encoder and a free query.
// Depends on ptq_pkg.
`timescale 1ns / 1ps

module ptq_slot_alloc
   import ptq_pkg::*;
#(
   parameter int SLOTS = 32
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              alloc_en,
   input  logic              release_en,
   input  logic [SLOT_W-1:0] query_slot,
   output logic              any_free,
   output logic [SLOT_W-1:0] low_slot,
   output logic              query_free,
   output logic [SLOTS-1:0]  free_mask
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [SLOTS-1:0] free_ff;
   logic [SLOTS-1:0] free_in;
   logic             in_range;

   assign free_mask = free_ff;
   assign any_free  = |free_ff;
   assign in_range  = ({1'b0, query_slot} < (SLOT_W + 1)'(SLOTS));

   // A slot index beyond the table reads as free, so finish ignores it.
   assign query_free = in_range ? free_ff[query_slot[IDX_W-1:0]] : 1'b1;

   always_comb begin
      low_slot = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            low_slot = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      free_in = free_ff;
      if (alloc_en) begin
         free_in[low_slot[IDX_W-1:0]] = 1'b0;
      end else if (release_en) begin
         free_in[query_slot[IDX_W-1:0]] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= '1;
      end else begin
         free_ff <= free_in;
      end
   end

endmodule
